@@ rtl/fpa_pkg.sv @@
package fpa_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int DIV_W = 32 + FRACTION_BITS;
  localparam int CNT_W = $clog2(DIV_W + 1);
  localparam int EXP_BIAS = 127 - FRACTION_BITS;

  typedef enum logic [4:0] {
    CMD_ADD = 5'd0,
    CMD_SUB = 5'd1,
    CMD_MUL = 5'd2,
    CMD_DIV = 5'd3,
    CMD_LT  = 5'd4,
    CMD_GT  = 5'd5,
    CMD_LE  = 5'd6,
    CMD_GE  = 5'd7,
    CMD_EQ  = 5'd8,
    CMD_NE  = 5'd9,
    CMD_MIN = 5'd10,
    CMD_MAX = 5'd11,
    CMD_INC = 5'd12,
    CMD_DEC = 5'd13,
    CMD_I2F = 5'd14,
    CMD_S2F = 5'd15,
    CMD_F2I = 5'd16,
    CMD_F2S = 5'd17
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_SIMPLE = 2'd0,
    KIND_DIV    = 2'd1,
    KIND_NORM   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [4:0]  cmd;
    logic [31:0] a;
    logic [31:0] b;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

endpackage

@@ rtl/fpa_front.sv @@
module fpa_front
  import fpa_pkg::*;
(
  input  logic        start_i,
  input  logic [4:0]  command_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  input  qstat_t      qstat_i,
  output logic        busy_o,
  output logic        push_o,
  output entry_t      entry_o
);

  kind_e kind;

  always_comb begin
    kind = KIND_SIMPLE;
    if (command_i == CMD_DIV && operand_b_i != 32'd0) begin
      kind = KIND_DIV;
    end else if (command_i == CMD_F2S && operand_a_i != 32'd0) begin
      kind = KIND_NORM;
    end
  end

  assign busy_o        = qstat_i.full;
  assign push_o        = start_i && !qstat_i.full;
  assign entry_o.kind  = kind;
  assign entry_o.cmd   = command_i;
  assign entry_o.a     = operand_a_i;
  assign entry_o.b     = operand_b_i;

endmodule

@@ rtl/fpa_queue.sv @@
module fpa_queue
  import fpa_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output entry_t head_o,
  output qstat_t qstat_o
);

  entry_t      mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  assign head_o        = mem_q[rd_q];
  assign qstat_o.full  = (cnt_q == 2'd2);
  assign qstat_o.empty = (cnt_q == 2'd0);

endmodule

@@ rtl/fpa_back.sv @@
module fpa_back
  import fpa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  entry_t      head_i,
  input  qstat_t      qstat_i,
  output logic        pop_o,
  output logic        done_o,
  output logic [31:0] result_o,
  output logic        compare_true_o,
  output logic        divide_by_zero_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_NORM = 3'b100
  } state_e;

  function automatic logic [31:0] s2f(input logic [31:0] f);
    logic              neg;
    logic [7:0]        ex;
    logic [22:0]       fr;
    logic [23:0]       m;
    logic signed [10:0] sh;
    logic [4:0]        rs;
    logic [4:0]        rs1;
    logic [23:0]       t;
    logic [23:0]       g;
    logic [63:0]       mag;
    logic [31:0]       r;
    neg = f[31];
    ex  = f[30:23];
    fr  = f[22:0];
    m   = (ex == 8'd0) ? {1'b0, fr} : {1'b1, fr};
    sh  = $signed({3'b000, ((ex == 8'd0) ? 8'd1 : ex)}) - 11'sd150
          + 11'(FRACTION_BITS);
    mag = 64'd0;
    rs  = 5'd0;
    rs1 = 5'd0;
    t   = 24'd0;
    g   = 24'd0;
    if (sh >= 11'sd40) begin
      mag = 64'd1 << 40;
    end else if (sh >= 11'sd0) begin
      mag = {40'd0, m} << sh[5:0];
    end else if (sh >= -11'sd25) begin
      rs  = 5'(-sh);
      rs1 = rs - 5'd1;
      t   = m >> rs;
      g   = m >> rs1;
      mag = {40'd0, t} + {63'd0, g[0]};
    end
    if (ex == 8'hFF) begin
      r = (fr != 23'd0) ? 32'd0 : (neg ? 32'h8000_0000 : 32'h7FFF_FFFF);
    end else if (m == 24'd0) begin
      r = 32'd0;
    end else if (neg) begin
      r = (mag > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
    end else begin
      r = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return r;
  endfunction

  state_e             state_q, state_d;
  logic [DIV_W-1:0]   num_q, num_d;
  logic [31:0]        rem_q, rem_d;
  logic [31:0]        dsr_q, dsr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               neg_q, neg_d;
  logic [31:0]        norm_q, norm_d;
  logic [4:0]         p_q, p_d;
  logic               valid_q, valid_d;
  logic [31:0]        res_q, res_d;
  logic               cmp_q, cmp_d;
  logic               dz_q, dz_d;

  logic [31:0]        a, b;
  logic               a_lt_b, b_lt_a;
  logic signed [63:0] prod;
  logic [31:0]        s_res;
  logic               s_cmp, s_dz;
  logic [32:0]        trial;
  logic               qbit;
  logic [DIV_W-1:0]   num_step;
  logic [23:0]        mant;
  logic               rup;
  logic [24:0]        msum;
  logic [23:0]        mant_f;
  logic [7:0]         e8;

  assign a      = head_i.a;
  assign b      = head_i.b;
  assign a_lt_b = $signed(a) < $signed(b);
  assign b_lt_a = $signed(b) < $signed(a);
  assign prod   = $signed(a) * $signed(b);

  always_comb begin
    s_res = 32'd0;
    s_cmp = 1'b0;
    s_dz  = 1'b0;
    case (head_i.cmd)
      CMD_ADD: s_res = a + b;
      CMD_SUB: s_res = a - b;
      CMD_MUL: s_res = prod[FRACTION_BITS+31:FRACTION_BITS];
      CMD_DIV: s_dz  = 1'b1;
      CMD_LT:  s_cmp = a_lt_b;
      CMD_GT:  s_cmp = b_lt_a;
      CMD_LE:  s_cmp = !b_lt_a;
      CMD_GE:  s_cmp = !a_lt_b;
      CMD_EQ:  s_cmp = (a == b);
      CMD_NE:  s_cmp = (a != b);
      CMD_MIN: s_res = b_lt_a ? b : a;
      CMD_MAX: s_res = a_lt_b ? b : a;
      CMD_INC: s_res = a + 32'd1;
      CMD_DEC: s_res = a - 32'd1;
      CMD_I2F: s_res = a << FRACTION_BITS;
      CMD_S2F: s_res = s2f(a);
      CMD_F2I: s_res = 32'($signed(a) >>> FRACTION_BITS);
      default: s_res = 32'd0;
    endcase
  end

  assign trial    = {rem_q, num_q[DIV_W-1]};
  assign qbit     = (trial >= {1'b0, dsr_q});
  assign num_step = {num_q[DIV_W-2:0], qbit};

  assign mant   = norm_q[31:8];
  assign rup    = norm_q[7] & ((|norm_q[6:0]) | mant[0]);
  assign msum   = {1'b0, mant} + {24'd0, rup};
  assign mant_f = msum[24] ? msum[24:1] : msum[23:0];
  assign e8     = {3'b000, p_q} + 8'(EXP_BIAS) + {7'd0, msum[24]};

  assign pop_o = (state_q == ST_IDLE) && !qstat_i.empty;

  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    norm_d  = norm_q;
    p_d     = p_q;
    valid_d = 1'b0;
    res_d   = res_q;
    cmp_d   = 1'b0;
    dz_d    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          unique case (head_i.kind)
            KIND_DIV: begin
              state_d = ST_DIV;
              num_d   = {mag32(a), {FRACTION_BITS{1'b0}}};
              rem_d   = 32'd0;
              dsr_d   = mag32(b);
              cnt_d   = CNT_W'(DIV_W);
              neg_d   = a[31] ^ b[31];
            end
            KIND_NORM: begin
              state_d = ST_NORM;
              norm_d  = mag32(a);
              p_d     = 5'd31;
              neg_d   = a[31];
            end
            default: begin
              valid_d = 1'b1;
              res_d   = s_res;
              cmp_d   = s_cmp;
              dz_d    = s_dz;
            end
          endcase
        end
      end
      ST_DIV: begin
        rem_d = qbit ? 32'(trial - {1'b0, dsr_q}) : trial[31:0];
        num_d = num_step;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_IDLE;
          valid_d = 1'b1;
          res_d   = neg_q ? (32'd0 - num_step[31:0]) : num_step[31:0];
        end
      end
      ST_NORM: begin
        if (norm_q[31]) begin
          state_d = ST_IDLE;
          valid_d = 1'b1;
          res_d   = {neg_q, e8, mant_f[22:0]};
        end else begin
          norm_d = {norm_q[30:0], 1'b0};
          p_d    = p_q - 5'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    cnt_q  <= cnt_d;
    neg_q  <= neg_d;
    norm_q <= norm_d;
    p_q    <= p_d;
    res_q  <= res_d;
    cmp_q  <= cmp_d;
    dz_q   <= dz_d;
  end

  assign done_o           = valid_q;
  assign result_o         = res_q;
  assign compare_true_o   = cmp_q;
  assign divide_by_zero_o = dz_q;

endmodule

@@ rtl/fixed_point_alu_unit.sv @@
// Signed 32-bit fixed-point arithmetic unit with FRACTION_BITS fraction bits.
// An operation is transferred at a rising edge with start_i high and busy_o
// low; command_i selects add, sub, mul, div, compares, min, max, inc, dec or
// a conversion, and operand_a_i and operand_b_i carry the raw patterns.
// Each operation yields one result, shown on result_o, compare_true_o and
// divide_by_zero_o for exactly one cycle while done_o is high.
// Results leave in the order the operations came in.
// A front stage classifies operations into a two-entry queue; a back stage
// executes them and registers the result.
// Most operations run at one per cycle while no long operation holds the back
// stage. A divide with a nonzero divisor iterates one quotient bit per cycle
// and holds the back stage for all 32 + FRACTION_BITS quotient bits. Fixed to
// single normalizes one bit per cycle, holding it until the top bit is one.
// busy_o rises only while the queue is full behind such a long operation.
// Reset empties the queue and drops any operation in flight.
// The receiver cannot stall, so done_o never waits.
module fixed_point_alu_unit
  import fpa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [4:0]  command_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        done_o,
  output logic [31:0] result_o,
  output logic        compare_true_o,
  output logic        divide_by_zero_o
);

  qstat_t qstat;
  logic   push, pop;
  entry_t entry, head;

  fpa_front u_front (
    .start_i     (start_i),
    .command_i   (command_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .qstat_i     (qstat),
    .busy_o      (busy_o),
    .push_o      (push),
    .entry_o     (entry)
  );

  fpa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  fpa_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .qstat_i          (qstat),
    .pop_o            (pop),
    .done_o           (done_o),
    .result_o         (result_o),
    .compare_true_o   (compare_true_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

endmodule

@@ rtl/fpa_checker.sv @@
module fpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [31:0] result_o,
  input logic        compare_true_o,
  input logic        divide_by_zero_o
);

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without a preceding transfer");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && divide_by_zero_o) |-> (result_o == 32'd0))
    else $error("divide by zero with nonzero result");

  a_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && compare_true_o) |-> (result_o == 32'd0))
    else $error("compare result with nonzero value");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(compare_true_o && divide_by_zero_o))
    else $error("both flags set");

endmodule

bind fixed_point_alu_unit fpa_checker u_fpa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .done_o           (done_o),
  .result_o         (result_o),
  .compare_true_o   (compare_true_o),
  .divide_by_zero_o (divide_by_zero_o)
);
